/* hdl/kotu_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the keyed object table update block
// no dependencies
package kotu_pkg;

	localparam int OBJ_TYPE_W  = 8;
	localparam int NUMBER_W    = 16;
	localparam int HEALTH_W    = 8;
	localparam int POS_W       = 32;
	localparam int SLOT_W      = 6;
	localparam int TCOUNT_W    = 7;
	localparam int ENTRIES_DEF = 64;
	localparam int TYPES_DEF   = 4;

	typedef enum logic [2:0] {
		ACT_UPDATED = 3'd0,
		ACT_REMOVED = 3'd1,
		ACT_ADDED   = 3'd2,
		ACT_FULL    = 3'd3,
		ACT_IGNORED = 3'd4,
		ACT_UNKNOWN = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [OBJ_TYPE_W-1:0]    obj_type;
		logic [NUMBER_W-1:0]      obj_number;
		logic signed [HEALTH_W-1:0] health;
		logic [POS_W-1:0]         pos_x;
		logic [POS_W-1:0]         pos_y;
	} rec_t;

	typedef struct packed {
		logic [NUMBER_W-1:0] key;
		logic [HEALTH_W-1:0] health;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
	} entry_t;

	typedef struct packed {
		action_t             action;
		logic [SLOT_W-1:0]   slot;
		logic [TCOUNT_W-1:0] type_count;
	} eng_res_t;

endpackage

/* hdl/kotu_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces: object records, results, own id writes
// depends on kotu_pkg
interface kotu_rec_if import kotu_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [OBJ_TYPE_W-1:0]      obj_type;
	logic [NUMBER_W-1:0]        obj_number;
	logic signed [HEALTH_W-1:0] health;
	logic [POS_W-1:0]           pos_x;
	logic [POS_W-1:0]           pos_y;

	modport source (output valid, obj_type, obj_number, health, pos_x, pos_y, input ready);
	modport sink (input valid, obj_type, obj_number, health, pos_x, pos_y, output ready);
endinterface

interface kotu_res_if import kotu_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [2:0]          action;
	logic [SLOT_W-1:0]   slot;
	logic [TCOUNT_W-1:0] type_count;
	logic                is_me;

	modport source (output valid, action, slot, type_count, is_me, input ready);
	modport sink (input valid, action, slot, type_count, is_me, output ready);
endinterface

interface kotu_cfg_if import kotu_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [NUMBER_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* hdl/kotu_engine.sv */
`timescale 1ns / 1ps
// table engine: entry memory, per-type counts, search and compaction sequencer
// depends on kotu_pkg
module kotu_engine import kotu_pkg::*; #(
	parameter int ENTRIES_PER_TYPE = ENTRIES_DEF,
	parameter int TYPE_COUNT       = TYPES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  rec_t     rec,
	output logic     idle,
	output logic     done,
	output eng_res_t res,
	input  logic     take
);

	localparam int IDX_W  = (ENTRIES_PER_TYPE > 1) ? $clog2(ENTRIES_PER_TYPE) : 1;
	localparam int TYP_W  = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
	localparam int CNT_W  = IDX_W + 1;
	localparam int ADDR_W = TYP_W + IDX_W;
	localparam int DEPTH  = TYPE_COUNT << IDX_W;

	state_t             state_q, state_d;
	rec_t               rec_q;
	logic [TYP_W-1:0]   typ_q;
	logic [CNT_W-1:0]   n_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   slot_q;
	logic [CNT_W-1:0]   cnt_q;
	action_t            act_q;
	logic [CNT_W-1:0]   counts_q [TYPE_COUNT];

	entry_t             mem [DEPTH];
	entry_t             rdata;

	logic               known;
	logic               hit;
	logic [CNT_W-1:0]   nxt1, nxt2;
	logic               rd_en, wr_en;
	logic [IDX_W-1:0]   rd_idx, wr_idx;
	logic [TYP_W-1:0]   rd_typ;
	entry_t             wr_data;
	logic               idx_inc;
	logic               slot_we;
	logic [IDX_W-1:0]   slot_d;
	logic               fin;
	action_t            act_d;
	logic [CNT_W-1:0]   cnt_d;
	logic               cnt_we;

	assign known = rec.obj_type < OBJ_TYPE_W'(TYPE_COUNT);
	assign nxt1  = CNT_W'(idx_q) + CNT_W'(1);
	assign nxt2  = nxt1 + CNT_W'(1);
	// entries at or above the count are masked by the comparison, so they never match
	assign hit   = (rdata.key == rec_q.obj_number) && (CNT_W'(idx_q) < n_q);

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_idx  = '0;
		rd_typ  = typ_q;
		wr_en   = 1'b0;
		wr_idx  = idx_q;
		wr_data = entry_t'{rec_q.obj_number, rec_q.health, rec_q.pos_x, rec_q.pos_y};
		idx_inc = 1'b0;
		slot_we = 1'b0;
		slot_d  = '0;
		fin     = 1'b0;
		act_d   = ACT_IGNORED;
		cnt_d   = n_q;
		cnt_we  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_typ = rec.obj_type[TYP_W-1:0];
				if (start) begin
					if (known) begin
						rd_en   = 1'b1;
						state_d = ST_SEARCH;
					end else begin
						fin     = 1'b1;
						act_d   = ACT_UNKNOWN;
						cnt_d   = '0;
						slot_we = 1'b1;
						state_d = ST_DONE;
					end
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					slot_we = 1'b1;
					slot_d  = idx_q;
					if (rec_q.health == '0) begin
						if (nxt1 < n_q) begin
							rd_en   = 1'b1;
							rd_idx  = nxt1[IDX_W-1:0];
							state_d = ST_SHIFT;
						end else begin
							fin     = 1'b1;
							act_d   = ACT_REMOVED;
							cnt_d   = n_q - CNT_W'(1);
							cnt_we  = 1'b1;
							state_d = ST_DONE;
						end
					end else begin
						wr_en   = 1'b1;
						fin     = 1'b1;
						act_d   = ACT_UPDATED;
						cnt_we  = 1'b1;
						state_d = ST_DONE;
					end
				end else if (nxt1 < n_q) begin
					rd_en   = 1'b1;
					rd_idx  = nxt1[IDX_W-1:0];
					idx_inc = 1'b1;
				end else begin
					fin     = 1'b1;
					cnt_we  = 1'b1;
					slot_we = 1'b1;
					state_d = ST_DONE;
					if (rec_q.health == '0) begin
						act_d = ACT_IGNORED;
					end else if (n_q < CNT_W'(ENTRIES_PER_TYPE)) begin
						wr_en  = 1'b1;
						wr_idx = n_q[IDX_W-1:0];
						slot_d = n_q[IDX_W-1:0];
						act_d  = ACT_ADDED;
						cnt_d  = n_q + CNT_W'(1);
					end else begin
						act_d = ACT_FULL;
					end
				end
			end
			ST_SHIFT: begin
				// rdata holds entry idx_q + 1, moved down one place
				wr_en   = 1'b1;
				wr_data = rdata;
				if (nxt2 < n_q) begin
					rd_en   = 1'b1;
					rd_idx  = nxt2[IDX_W-1:0];
					idx_inc = 1'b1;
				end else begin
					fin     = 1'b1;
					act_d   = ACT_REMOVED;
					cnt_d   = n_q - CNT_W'(1);
					cnt_we  = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int t = 0; t < TYPE_COUNT; t++) begin
				counts_q[t] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cnt_we) begin
				counts_q[typ_q] <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rec_q <= rec;
			typ_q <= rec.obj_type[TYP_W-1:0];
			n_q   <= counts_q[rec.obj_type[TYP_W-1:0]];
			idx_q <= '0;
		end else if (idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (slot_we) begin
			slot_q <= slot_d;
		end
		if (fin) begin
			act_q <= act_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ADDR_W'({typ_q, wr_idx})] <= wr_data;
		end
		if (rd_en) begin
			rdata <= mem[ADDR_W'({rd_typ, rd_idx})];
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign res  = eng_res_t'{act_q, SLOT_W'(slot_q), TCOUNT_W'(cnt_q)};

endmodule

/* hdl/keyed_object_table_update_top.sv */
`timescale 1ns / 1ps
// an unknown type goes straight to the done state; a known type searches its table,
// one memory read per entry examined, and on a removal moves each later entry down one place
// the engine works on one record at a time; its result then passes to the output register
// the next record is taken while the previous result still waits in the output register
// reset clears per-type counts, own id and control; the entry memory is not cleared,
// entries above a type's count are never read
module keyed_object_table_update_top import kotu_pkg::*; #(
	parameter int ENTRIES_PER_TYPE = ENTRIES_DEF,
	parameter int TYPE_COUNT       = TYPES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	kotu_rec_if.sink   rec,
	kotu_res_if.source res,
	kotu_cfg_if.sink   cfg
);

	logic [NUMBER_W-1:0] own_id_q;
	logic                is_me_q;
	logic                out_valid_q;
	eng_res_t            out_q;
	logic                is_me_out_q;

	logic                eng_idle, eng_done, start, take;
	eng_res_t            eng_res;
	rec_t                rec_word;

	assign rec_word = rec_t'{rec.obj_type, rec.obj_number, rec.health, rec.pos_x, rec.pos_y};
	assign rec.ready = eng_idle;
	assign start     = rec.valid && eng_idle;
	assign take      = eng_done && (!out_valid_q || res.ready);
	assign cfg.ready = 1'b1;

	kotu_engine #(
		.ENTRIES_PER_TYPE (ENTRIES_PER_TYPE),
		.TYPE_COUNT       (TYPE_COUNT)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.rec    (rec_word),
		.idle   (eng_idle),
		.done   (eng_done),
		.res    (eng_res),
		.take   (take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				own_id_q <= cfg.data;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			is_me_q <= (rec.obj_type == '0) && (rec.obj_number == own_id_q);
		end
		if (take) begin
			out_q       <= eng_res;
			is_me_out_q <= is_me_q;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.action     = out_q.action;
	assign res.slot       = out_q.slot;
	assign res.type_count = out_q.type_count;
	assign res.is_me      = is_me_out_q;

endmodule

/* verif/keyed_object_table_update_top_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for keyed_object_table_update_top: per-type keyed tables
// needs kotu_pkg, the channel interfaces of kotu_if and the block itself
module keyed_object_table_update_top_tb;
	import kotu_pkg::*;

	localparam int RUN_LIMIT   = 1200000;
	localparam int TAIL_CYCLES = 2 * ENTRIES_DEF + 8;
	localparam int MAX_SHOWN   = 10;

	typedef struct {
		action_t             action;
		logic [SLOT_W-1:0]   slot;
		logic [TCOUNT_W-1:0] type_count;
		logic                is_me;
	} table_result_t;

	logic clk;
	logic arst_n;

	kotu_rec_if rec_ch ();
	kotu_res_if res_ch ();
	kotu_cfg_if cfg_ch ();

	keyed_object_table_update_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rec    (rec_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// shadow of the tables, counts and own id
	entry_t              obj_tbl [TYPES_DEF][ENTRIES_DEF];
	int                  obj_count [TYPES_DEF];
	logic [NUMBER_W-1:0] own_id_shadow = '0;
	table_result_t       pending_results [$];
	int                  err_count   = 0;
	int                  cycle_count = 0;
	bit                  idle_on     = 1'b1;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// result side: random stall bursts while idling is on
	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!idle_on) begin
				stall_left = 0;
				res_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic note_failure(input string msg);
		err_count++;
		if (err_count <= MAX_SHOWN) begin
			$display("%s", msg);
		end
	endtask

	always @(posedge clk) begin : check_result
		table_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("tb: result word with none pending: act %0d slot %0d cnt %0d me %0b",
					res_ch.action, res_ch.slot, res_ch.type_count, res_ch.is_me));
			end else begin
				want = pending_results.pop_front();
				if (res_ch.action !== want.action || res_ch.slot !== want.slot ||
						res_ch.type_count !== want.type_count || res_ch.is_me !== want.is_me) begin
					note_failure($sformatf(
						"tb: mismatch cycle %0d: want act %0d slot %0d cnt %0d me %0b, got %0d %0d %0d %0b",
						cycle_count, want.action, want.slot, want.type_count, want.is_me,
						res_ch.action, res_ch.slot, res_ch.type_count, res_ch.is_me));
				end
			end
		end
	end

	function automatic table_result_t predict_update(input rec_t r);
		table_result_t o;
		int t;
		int n;
		int hit;
		int i;
		o.is_me      = (r.obj_type == '0) && (r.obj_number == own_id_shadow);
		o.slot       = '0;
		o.type_count = '0;
		if (int'(r.obj_type) >= TYPES_DEF) begin
			o.action = ACT_UNKNOWN;
		end else begin
			t   = int'(r.obj_type);
			n   = obj_count[t];
			hit = -1;
			for (i = 0; i < n; i++) begin
				if (hit < 0 && obj_tbl[t][i].key == r.obj_number) begin
					hit = i;
				end
			end
			if (hit >= 0) begin
				o.slot = SLOT_W'(hit);
				if (r.health == '0) begin
					// later entries move down one slot
					for (i = hit; i + 1 < n; i++) begin
						obj_tbl[t][i] = obj_tbl[t][i + 1];
					end
					n--;
					o.action = ACT_REMOVED;
				end else begin
					obj_tbl[t][hit] = '{r.obj_number, r.health, r.pos_x, r.pos_y};
					o.action = ACT_UPDATED;
				end
			end else if (r.health != '0) begin
				if (n < ENTRIES_DEF) begin
					obj_tbl[t][n] = '{r.obj_number, r.health, r.pos_x, r.pos_y};
					o.slot = SLOT_W'(n);
					n++;
					o.action = ACT_ADDED;
				end else begin
					o.action = ACT_FULL;
				end
			end else begin
				o.action = ACT_IGNORED;
			end
			obj_count[t] = n;
			o.type_count = TCOUNT_W'(n);
		end
		return o;
	endfunction

	function automatic rec_t mk_rec(input logic [OBJ_TYPE_W-1:0] t, input logic [NUMBER_W-1:0] n,
			input logic [HEALTH_W-1:0] h, input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
		rec_t r;
		r.obj_type   = t;
		r.obj_number = n;
		r.health     = h;
		r.pos_x      = x;
		r.pos_y      = y;
		return r;
	endfunction

	function automatic rec_t random_record(input logic [NUMBER_W-1:0] key_base, input int pool,
			input int zero_pct);
		rec_t r;
		if ($urandom_range(0, 99) < 88) begin
			r.obj_type = OBJ_TYPE_W'($urandom_range(0, TYPES_DEF - 1));
		end else begin
			r.obj_type = OBJ_TYPE_W'($urandom_range(TYPES_DEF, 255));
		end
		// mostly keys from a small pool so that lookups hit
		if ($urandom_range(0, 99) < 75) begin
			r.obj_number = NUMBER_W'(key_base + $urandom_range(0, pool - 1));
		end else begin
			r.obj_number = NUMBER_W'($urandom);
		end
		if ($urandom_range(0, 99) < zero_pct) begin
			r.health = '0;
		end else begin
			r.health = HEALTH_W'($urandom_range(1, 255));
		end
		r.pos_x = $urandom;
		r.pos_y = $urandom;
		return r;
	endfunction

	task automatic send_record(input rec_t r);
		rec_ch.valid      <= 1'b1;
		rec_ch.obj_type   <= r.obj_type;
		rec_ch.obj_number <= r.obj_number;
		rec_ch.health     <= r.health;
		rec_ch.pos_x      <= r.pos_x;
		rec_ch.pos_y      <= r.pos_y;
		do @(posedge clk); while (!rec_ch.ready);
		pending_results.push_back(predict_update(r));
		if (idle_on && $urandom_range(0, 3) == 0) begin
			rec_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic wait_results_done();
		rec_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_own_id(input logic [NUMBER_W-1:0] id);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= id;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		own_id_shadow = id;
	endtask

	// own id is still at its reset value of zero here
	task automatic test_directed_edges();
		send_record(mk_rec(8'd0, 16'd0, 8'd1, 32'h0, 32'h0));
		send_record(mk_rec(8'd0, 16'd0, 8'h80, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_record(mk_rec(8'd0, 16'd0, 8'h00, 32'h0, 32'h0));
		send_record(mk_rec(8'd0, 16'd0, 8'h00, 32'h1234_5678, 32'h0));
		send_record(mk_rec(8'd1, 16'hFFFF, 8'h7F, 32'hFFFF_FFFF, 32'h0));
		send_record(mk_rec(8'd1, 16'd100, 8'hFF, 32'h0, 32'hFFFF_FFFF));
		send_record(mk_rec(8'd1, 16'd200, 8'd1, 32'h3F80_0000, 32'hBF80_0000));
		// removal from the front shifts the other two down
		send_record(mk_rec(8'd1, 16'hFFFF, 8'h00, 32'h0, 32'h0));
		send_record(mk_rec(8'd1, 16'd200, 8'd55, 32'h0, 32'h0));
		send_record(mk_rec(8'd1, 16'd300, 8'h00, 32'h0, 32'h0));
		send_record(mk_rec(8'd4, 16'd1, 8'd5, 32'h0, 32'h0));
		send_record(mk_rec(8'hFF, 16'hFFFF, 8'h80, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_record(mk_rec(8'h80, 16'd0, 8'h00, 32'h0, 32'h0));
		send_record(mk_rec(8'd2, 16'd0, 8'd1, 32'h0, 32'h0));
		send_record(mk_rec(8'd3, 16'h5555, 8'hFF, 32'hAAAA_AAAA, 32'h5555_5555));
		send_record(mk_rec(8'd3, 16'hAAAA, 8'd1, 32'h5555_5555, 32'hAAAA_AAAA));
		send_record(mk_rec(8'd1, 16'd100, 8'h00, 32'h0, 32'h0));
		send_record(mk_rec(8'd1, 16'd200, 8'h00, 32'h0, 32'h0));
	endtask

	task automatic test_own_id_match();
		wait_results_done();
		write_own_id(16'hFFFF);
		send_record(mk_rec(8'd0, 16'hFFFF, 8'd3, 32'h4000_0000, 32'hC000_0000));
		send_record(mk_rec(8'd0, 16'hFFFF, 8'h00, 32'h0, 32'h0));
		send_record(mk_rec(8'd1, 16'hFFFF, 8'd9, 32'h0, 32'h0));
		send_record(mk_rec(8'd0, 16'hFFFE, 8'd1, 32'h0, 32'h0));
		send_record(mk_rec(8'd7, 16'hFFFF, 8'd2, 32'h0, 32'h0));
	endtask

	// empty one table, fill it to the top, push past it, update, then optionally empty it again
	task automatic test_table_full(input int t, input bit drain_after);
		logic [NUMBER_W-1:0] first;
		int i;
		while (obj_count[t] > 0) begin
			send_record(mk_rec(OBJ_TYPE_W'(t), obj_tbl[t][$urandom_range(0, obj_count[t] - 1)].key,
				8'h00, $urandom, $urandom));
		end
		first = NUMBER_W'($urandom);
		for (i = 0; i < ENTRIES_DEF; i++) begin
			send_record(mk_rec(OBJ_TYPE_W'(t), first + NUMBER_W'(7 * i),
				HEALTH_W'($urandom_range(1, 255)), $urandom, $urandom));
		end
		for (i = 0; i < 4; i++) begin
			send_record(mk_rec(OBJ_TYPE_W'(t), first + NUMBER_W'(7 * ENTRIES_DEF + i),
				HEALTH_W'($urandom_range(1, 255)), $urandom, $urandom));
		end
		send_record(mk_rec(OBJ_TYPE_W'(t), first + NUMBER_W'(7 * ENTRIES_DEF + 10), 8'h00,
			$urandom, $urandom));
		for (i = 0; i < 6; i++) begin
			send_record(mk_rec(OBJ_TYPE_W'(t), obj_tbl[t][$urandom_range(0, ENTRIES_DEF - 1)].key,
				HEALTH_W'($urandom_range(1, 255)), $urandom, $urandom));
		end
		if (drain_after) begin
			while (obj_count[t] > 0) begin
				send_record(mk_rec(OBJ_TYPE_W'(t),
					obj_tbl[t][$urandom_range(0, obj_count[t] - 1)].key, 8'h00,
					$urandom, $urandom));
			end
		end
	endtask

	task automatic test_random_mix(input int items, input logic [NUMBER_W-1:0] key_base,
			input int pool, input int zero_pct, input bit with_idle, input logic [NUMBER_W-1:0] id);
		int i;
		wait_results_done();
		write_own_id(id);
		idle_on = with_idle;
		for (i = 0; i < items; i++) begin
			if (with_idle && i % 100 == 0) begin
				idle_on = ($urandom_range(0, 3) != 0);
			end
			// halfway through, the sender holds off until every word is back
			if (i == items / 2) begin
				wait_results_done();
			end
			send_record(random_record(key_base, pool, zero_pct));
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		rec_ch.valid      <= 1'b0;
		rec_ch.obj_type   <= '0;
		rec_ch.obj_number <= '0;
		rec_ch.health     <= '0;
		rec_ch.pos_x      <= '0;
		rec_ch.pos_y      <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.data       <= '0;
		for (int t = 0; t < TYPES_DEF; t++) begin
			obj_count[t] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_own_id_match();
		wait_results_done();
		write_own_id(NUMBER_W'($urandom));
		test_table_full($urandom_range(0, TYPES_DEF - 1), 1'b1);
		test_table_full(0, 1'b0);
		test_random_mix(500, 16'h0000, 80, 30, 1'b1, NUMBER_W'($urandom_range(0, 79)));
		test_random_mix(300, 16'hFFB0, 90, 6, 1'b1, 16'hFFFF);
		test_random_mix(250, 16'hFFB0, 90, 70, 1'b1, NUMBER_W'(16'hFFB0 + $urandom_range(0, 89)));
		test_random_mix(220, 16'h0000, 80, 30, 1'b0, 16'h0000);

		wait_results_done();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
